>>> rtl/tksd_pkg.sv
// Shared types, constants and code points for the terminal key sequence decoder.
// No dependencies; every other file in rtl/ imports this package.
package tksd_pkg;

    // Push-back stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Input operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Byte values
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_UA     = 8'h41;  // A
    localparam logic [7:0] CH_UB     = 8'h42;  // B
    localparam logic [7:0] CH_UC     = 8'h43;  // C
    localparam logic [7:0] CH_UD     = 8'h44;  // D
    localparam logic [7:0] CH_UF     = 8'h46;  // F
    localparam logic [7:0] CH_UH     = 8'h48;  // H
    localparam logic [7:0] CH_LA     = 8'h61;  // a
    localparam logic [7:0] CH_LE     = 8'h65;  // e
    localparam logic [7:0] CH_LF     = 8'h66;  // f
    localparam logic [7:0] LEAD1_LO  = 8'h81;
    localparam logic [7:0] LEAD1_HI  = 8'h9F;
    localparam logic [7:0] LEAD2_LO  = 8'hE0;
    localparam logic [7:0] LEAD2_HI  = 8'hFC;

    // Key codes
    localparam logic [15:0] KEY_NONE   = 16'h0000;
    localparam logic [15:0] KEY_ESC    = 16'd27;
    localparam logic [7:0]  EXT_PREFIX = 8'h01;   // 0x100 | byte
    localparam logic [15:0] KEY_UP     = 16'h0148;
    localparam logic [15:0] KEY_DOWN   = 16'h0150;
    localparam logic [15:0] KEY_RIGHT  = 16'h014D;
    localparam logic [15:0] KEY_LEFT   = 16'h014B;
    localparam logic [15:0] KEY_HOME   = 16'h0147;
    localparam logic [15:0] KEY_END    = 16'h014F;
    localparam logic [15:0] KEY_INS    = 16'h0152;
    localparam logic [15:0] KEY_DEL    = 16'h0153;

    // CSI parameter
    localparam logic [9:0]  PAR_MAX  = 10'd1023;
    localparam logic [9:0]  PAR_SEMI = 10'd500;
    localparam logic [9:0]  PAR_INS  = 10'd2;
    localparam logic [9:0]  PAR_DEL  = 10'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] key_code;
        logic        last;
        logic        push_dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        K_BYTE,
        K_PUSH,
        K_DRAIN
    } t_cmd_kind;

    typedef enum logic [2:0] {
        C_NUL,
        C_ESC,
        C_LEAD,
        C_DIGIT,
        C_SEMI,
        C_LBRACK,
        C_SKIP,
        C_OTHER
    } t_byte_cls;

    typedef struct packed {
        t_cmd_kind   kind;
        t_byte_cls   cls;
        logic [15:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        P_IDLE,
        P_LEAD,
        P_EXT,
        P_ESC,
        P_CSI,
        P_SKIP
    } t_parse_state;

    typedef enum logic {
        B_READY,
        B_DRAIN
    } t_back_state;

    typedef struct packed {
        logic         produce;
        logic [15:0]  key;
        t_parse_state state;
        logic [7:0]   lead;
        logic [9:0]   param;
    } t_byte_res;

endpackage

>>> rtl/tksd_front.sv
// Front end: takes input requests, classifies operation and terminal byte,
// and hands commands to the queue. Depends on tksd_pkg.
module tksd_front (
    input  logic              i_in_valid,
    input  tksd_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  tksd_pkg::t_q_stat i_q_stat,
    output logic              o_q_push,
    output tksd_pkg::t_cmd    o_q_cmd
);
    import tksd_pkg::*;

    logic      cmd_ok;
    t_cmd_kind kind;
    t_byte_cls cls;
    logic [7:0] b;

    assign b = i_in_item.data[7:0];

    always_comb begin
        cmd_ok = 1'b1;
        kind   = K_BYTE;
        unique case (i_in_item.operation)
            OP_BYTE:  kind = K_BYTE;
            OP_PUSH:  kind = K_PUSH;
            OP_DRAIN: kind = K_DRAIN;
            default:  cmd_ok = 1'b0;   // unused code: accept and drop
        endcase
    end

    always_comb begin
        priority if (b == CH_NUL) begin
            cls = C_NUL;
        end else if (b == CH_ESC) begin
            cls = C_ESC;
        end else if ((b >= LEAD1_LO && b <= LEAD1_HI) || (b >= LEAD2_LO && b <= LEAD2_HI)) begin
            cls = C_LEAD;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            cls = C_DIGIT;
        end else if (b == CH_SEMI) begin
            cls = C_SEMI;
        end else if (b == CH_LBRACK) begin
            cls = C_LBRACK;
        end else if (b == CH_HASH || b == CH_PCT || b == CH_LPAREN || b == CH_RPAREN) begin
            cls = C_SKIP;
        end else begin
            cls = C_OTHER;
        end
    end

    assign o_in_stall   = i_q_stat.full;
    assign o_q_push     = i_in_valid && !i_q_stat.full && cmd_ok;
    assign o_q_cmd.kind = kind;
    assign o_q_cmd.cls  = cls;
    assign o_q_cmd.data = i_in_item.data;

endmodule

>>> rtl/tksd_queue.sv
// Short command FIFO between the front end and the back end.
// Depends on tksd_pkg for the command type and depth.
module tksd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tksd_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output tksd_pkg::t_cmd    o_cmd,
    output tksd_pkg::t_q_stat o_stat
);
    import tksd_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

>>> rtl/tksd_back.sv
// Back end: byte parser, push-back stack and output register.
// Depends on tksd_pkg for command, parse state and result types.
module tksd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_esc_en,
    input  tksd_pkg::t_q_stat   i_q_stat,
    input  tksd_pkg::t_cmd      i_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tksd_pkg::t_out_item o_out_item
);
    import tksd_pkg::*;

    logic [15:0]       r_stack [STACK_DEPTH];
    logic [15:0]       r_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_en;

    t_back_state  r_bstate, n_bstate;
    t_parse_state r_parse, n_parse;
    logic [7:0]   r_lead, n_lead;
    logic [9:0]   r_param, n_param;

    logic      r_out_valid;
    t_out_item r_out_item;
    logic      ld_ok, emit;
    t_out_item emit_item;
    t_byte_res bres;

    function automatic logic [15:0] csi_final(input logic [7:0] b, input logic [9:0] par);
        logic [15:0] k;
        k = KEY_NONE;
        if (par <= 10'd1) begin
            priority case (b)
                CH_UA:        k = KEY_UP;
                CH_UB, CH_LE: k = KEY_DOWN;
                CH_UC, CH_LA: k = KEY_RIGHT;
                CH_UD:        k = KEY_LEFT;
                CH_UH, CH_LF: k = KEY_HOME;
                CH_UF:        k = KEY_END;
                default:      k = KEY_NONE;
            endcase
        end else if (b == CH_TILDE) begin
            if (par == PAR_INS) begin
                k = KEY_INS;
            end else if (par == PAR_DEL) begin
                k = KEY_DEL;
            end
        end
        return k;
    endfunction

    function automatic t_byte_res byte_step(
        input t_parse_state st,
        input t_byte_cls    cls,
        input logic [7:0]   b,
        input logic [7:0]   lead,
        input logic [9:0]   par,
        input logic         esc_en
    );
        t_byte_res   r;
        logic [13:0] v;
        r.produce = 1'b0;
        r.key     = KEY_NONE;
        r.state   = P_IDLE;
        r.lead    = lead;
        r.param   = par;
        v = ({4'b0, par} << 3) + ({4'b0, par} << 1) + 14'(b - CH_ZERO);
        unique case (st)
            P_LEAD: begin
                r.produce = 1'b1;
                r.key     = {lead, b};
            end
            P_EXT: begin
                r.produce = 1'b1;
                r.key     = {EXT_PREFIX, b};
            end
            P_ESC: begin
                if (cls == C_LBRACK) begin
                    r.param = '0;
                    r.state = P_CSI;
                end else if (cls == C_SKIP) begin
                    r.state = P_SKIP;
                end else begin
                    r.produce = 1'b1;
                end
            end
            P_SKIP: begin
                r.produce = 1'b1;
            end
            P_CSI: begin
                if (cls == C_DIGIT) begin
                    r.state = P_CSI;
                    r.param = (v > 14'(PAR_MAX)) ? PAR_MAX : v[9:0];
                end else if (cls == C_SEMI) begin
                    r.state = P_CSI;
                    r.param = PAR_SEMI;
                end else begin
                    r.produce = 1'b1;
                    r.key     = csi_final(b, par);
                end
            end
            default: begin
                if (cls == C_NUL) begin
                    r.state = P_EXT;
                end else if (cls == C_ESC) begin
                    if (esc_en) begin
                        r.state = P_ESC;
                    end else begin
                        r.produce = 1'b1;
                        r.key     = KEY_ESC;
                    end
                end else if (cls == C_LEAD) begin
                    r.lead  = b;
                    r.state = P_LEAD;
                end else begin
                    r.produce = 1'b1;
                    r.key     = {8'h00, b};
                end
            end
        endcase
        return r;
    endfunction

    assign ld_ok = !r_out_valid || !i_out_stall;
    assign bres  = byte_step(r_parse, i_cmd.cls, i_cmd.data[7:0], r_lead, r_param, i_esc_en);

    always_comb begin
        n_bstate  = r_bstate;
        n_count   = r_count;
        n_parse   = r_parse;
        n_lead    = r_lead;
        n_param   = r_param;
        emit      = 1'b0;
        emit_item = '0;
        o_q_pop   = 1'b0;
        wr_en     = 1'b0;
        unique case (r_bstate)
            B_READY: begin
                if (!i_q_stat.empty) begin
                    unique case (i_cmd.kind)
                        K_PUSH: begin
                            if (r_count < CNT_W'(STACK_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                o_q_pop = 1'b1;
                            end else if (ld_ok) begin
                                // full stack: drop and report
                                emit                   = 1'b1;
                                emit_item.key_code     = KEY_NONE;
                                emit_item.last         = 1'b1;
                                emit_item.push_dropped = 1'b1;
                                o_q_pop                = 1'b1;
                            end
                        end
                        K_DRAIN: begin
                            if (r_count == '0) begin
                                o_q_pop = 1'b1;
                            end else begin
                                n_bstate = B_DRAIN;
                            end
                        end
                        K_BYTE: begin
                            if (r_count != '0) begin
                                n_bstate = B_DRAIN;
                            end else if (!bres.produce || ld_ok) begin
                                n_parse            = bres.state;
                                n_lead             = bres.lead;
                                n_param            = bres.param;
                                emit               = bres.produce;
                                emit_item.key_code = bres.key;
                                emit_item.last     = 1'b1;
                                o_q_pop            = 1'b1;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            default: begin
                // emit stacked keys newest first; the head command stays queued
                if (ld_ok) begin
                    emit               = 1'b1;
                    emit_item.key_code = r_rd;
                    emit_item.last     = (r_count == CNT_W'(1)) &&
                                         (i_cmd.kind != K_BYTE || !bres.produce);
                    n_count            = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_bstate = B_READY;
                        if (i_cmd.kind != K_BYTE) begin
                            o_q_pop = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    assign rd_idx  = n_count - 1'b1;
    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign wr_addr = r_count[ADDR_W-1:0];

    // Stack memory; read data tracks the next top, with write bypass
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= i_cmd.data;
            r_rd             <= i_cmd.data;
        end else begin
            r_rd <= r_stack[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= B_READY;
            r_count     <= '0;
            r_parse     <= P_IDLE;
            r_lead      <= '0;
            r_param     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            r_count  <= n_count;
            r_parse  <= n_parse;
            r_lead   <= n_lead;
            r_param  <= n_param;
            if (ld_ok) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_ok && emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: front end, command queue,
// back end and the configuration register. Depends on tksd_pkg.

// Turns a stream of terminal bytes into 16-bit key codes and keeps a stack of
// pushed-back keys. Each input request carries an operation (terminal byte,
// push back a key, drain the stack) and a 16-bit data word; each result
// carries a key code, a last flag on the final result of a request, and a
// push_dropped flag when a push found the stack full. The front end
// classifies requests and hands them to a two-entry command queue, so input
// requests are taken until it fills while the back end waits on stalled output;
// the back end runs one command at a time. A push with room or a drain of an
// empty stack is retired without a result; a byte with an empty stack is parsed
// and its key is registered and shown in the cycle after. A byte or drain with
// N stacked keys first moves the back end to its drain state, which then emits
// one key per cycle while the output is not stalled (set by the single read port
// of the stack memory), newest first; a byte is then parsed on its own. Results
// leave through an output register that holds while i_out_stall is high.
// esc_sequences_enable is written through i_cfg_we / i_cfg_data and takes
// effect when an ESC byte is parsed; write it only while the block is idle.
module terminal_key_sequence_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tksd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tksd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);
    import tksd_pkg::*;

    logic    r_esc_en;
    logic    q_push, q_pop;
    t_cmd    q_in_cmd, q_out_cmd;
    t_q_stat q_stat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_esc_en <= i_cfg_data;
        end
    end

    // Accept and classify requests
    tksd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    // Hold commands between the two halves
    tksd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_stat  (q_stat)
    );

    // Parse bytes, run the stack, drive results
    tksd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_esc_en    (r_esc_en),
        .i_q_stat    (q_stat),
        .i_cmd       (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/tksd_checker.sv
// Port-level checks for the terminal key sequence decoder, bound to the top.
// Depends on tksd_pkg and terminal_key_sequence_decoder.
module tksd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tksd_pkg::t_out_item o_out_item
);
    import tksd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A dropped push is reported alone with key 0
    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.push_dropped |->
            o_out_item.last && o_out_item.key_code == KEY_NONE)
        else $error("malformed drop report");

    // Results of one request follow back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last |=> o_out_valid)
        else $error("gap inside a result burst");

    // Reset clears the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for terminal_key_sequence_decoder: directed and random
// terminal bytes, push-backs and drains, checked against an in-bench key decoder.
// Depends on tksd_pkg and the RTL of the block only.
module tb;
    import tksd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 40;    // longest drain plus pipeline, with margin
    localparam int RX_HOLD_CYCLES = 150;   // long receiver hold-off to back up the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving either way
    localparam int IDLE_PCT       = 8;

    // Scoreboard: decodes every accepted request into the keys it must produce
    // and checks each result against the oldest one still outstanding.
    class key_checker;
        t_parse_state parse_st;
        logic [7:0]   lead_byte;
        logic [9:0]   csi_param;
        logic [15:0]  key_stack [STACK_DEPTH];
        int           stack_fill;
        bit           esc_decode;
        t_out_item    expected_keys [$];
        int           errors;

        function new();
            parse_st   = P_IDLE;
            lead_byte  = '0;
            csi_param  = '0;
            stack_fill = 0;
            esc_decode = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction

        function void add_key(logic [15:0] key, logic dropped);
            t_out_item item;
            item.key_code     = key;
            item.last         = 1'b0;
            item.push_dropped = dropped;
            expected_keys.push_back(item);
        endfunction

        // Pop the stacked keys newest first; returns how many were emitted.
        function int unstack_all();
            int n;
            n = 0;
            while (stack_fill > 0) begin
                stack_fill--;
                add_key(key_stack[stack_fill], 1'b0);
                n++;
            end
            return n;
        endfunction

        function logic [15:0] csi_key(logic [7:0] b);
            if (csi_param <= 10'd1) begin
                case (b)
                    CH_UA:        return KEY_UP;
                    CH_UB, CH_LE: return KEY_DOWN;
                    CH_UC, CH_LA: return KEY_RIGHT;
                    CH_UD:        return KEY_LEFT;
                    CH_UH, CH_LF: return KEY_HOME;
                    CH_UF:        return KEY_END;
                    default:      return KEY_NONE;
                endcase
            end
            if (b == CH_TILDE && csi_param == PAR_INS) return KEY_INS;
            if (b == CH_TILDE && csi_param == PAR_DEL) return KEY_DEL;
            return KEY_NONE;
        endfunction

        // Advance the byte parser; returns 1 when the byte completes a key.
        function bit decode_byte(input logic [7:0] b, output logic [15:0] key);
            int unsigned acc;
            key = KEY_NONE;
            case (parse_st)
                P_LEAD: begin
                    parse_st = P_IDLE;
                    key = {lead_byte, b};
                    return 1'b1;
                end
                P_EXT: begin
                    parse_st = P_IDLE;
                    key = {EXT_PREFIX, b};
                    return 1'b1;
                end
                P_ESC: begin
                    if (b == CH_LBRACK) begin
                        csi_param = '0;
                        parse_st = P_CSI;
                        return 1'b0;
                    end
                    if (b == CH_HASH || b == CH_PCT || b == CH_LPAREN || b == CH_RPAREN) begin
                        parse_st = P_SKIP;
                        return 1'b0;
                    end
                    parse_st = P_IDLE;
                    return 1'b1;
                end
                P_SKIP: begin
                    parse_st = P_IDLE;
                    return 1'b1;
                end
                P_CSI: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        acc = int'(csi_param) * 10 + int'(b - CH_ZERO);
                        csi_param = (acc > PAR_MAX) ? PAR_MAX : acc[9:0];
                        return 1'b0;
                    end
                    if (b == CH_SEMI) begin
                        csi_param = PAR_SEMI;
                        return 1'b0;
                    end
                    parse_st = P_IDLE;
                    key = csi_key(b);
                    return 1'b1;
                end
                default: begin
                    parse_st = P_IDLE;
                    if (b == CH_NUL) begin
                        parse_st = P_EXT;
                        return 1'b0;
                    end
                    if (b == CH_ESC) begin
                        if (esc_decode) begin
                            parse_st = P_ESC;
                            return 1'b0;
                        end
                        key = KEY_ESC;
                        return 1'b1;
                    end
                    if ((b >= LEAD1_LO && b <= LEAD1_HI) || (b >= LEAD2_LO && b <= LEAD2_HI)) begin
                        lead_byte = b;
                        parse_st = P_LEAD;
                        return 1'b0;
                    end
                    key = {8'h00, b};
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_request(t_in_item req);
            int          n;
            logic [15:0] key;
            n = 0;
            case (req.operation)
                OP_BYTE: begin
                    n = unstack_all();
                    if (decode_byte(req.data[7:0], key)) begin
                        add_key(key, 1'b0);
                        n++;
                    end
                end
                OP_PUSH: begin
                    if (stack_fill < STACK_DEPTH) begin
                        key_stack[stack_fill] = req.data;
                        stack_fill++;
                    end else begin
                        add_key(KEY_NONE, 1'b1);
                        n = 1;
                    end
                end
                OP_DRAIN: n = unstack_all();
                default: ;
            endcase
            if (n > 0) expected_keys[expected_keys.size() - 1].last = 1'b1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_keys.size() == 0) begin
                $display("%0t: unexpected result key_code=%h last=%b push_dropped=%b",
                         $time, got.key_code, got.last, got.push_dropped);
                errors++;
                return;
            end
            want = expected_keys.pop_front();
            if (got.key_code !== want.key_code) begin
                $display("%0t: key_code expected %h actual %h",
                         $time, want.key_code, got.key_code);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
            if (got.push_dropped !== want.push_dropped) begin
                $display("%0t: push_dropped expected %b actual %b",
                         $time, want.push_dropped, got.push_dropped);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    key_checker  chk;
    int unsigned tx_idle_pct = IDLE_PCT;
    int unsigned rx_idle_pct = IDLE_PCT;
    bit          rx_hold_req = 1'b0;
    int          sent_count  = 0;
    int          stuck_cycles = 0;

    terminal_key_sequence_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Offer one request, with an occasional gap first; return at the edge
    // that accepts it.
    task automatic send_op(logic [1:0] op, logic [15:0] data);
        t_in_item req;
        req.operation = op;
        req.data      = data;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        chk.note_request(req);
        sent_count++;
    endtask

    // Terminal byte with random upper bits, which the block must ignore.
    task automatic send_byte(logic [7:0] b);
        send_op(OP_BYTE, {8'($urandom_range(255)), b});
    endtask

    task automatic send_any_byte();
        send_byte(8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every expected key is out and the back end
    // has had time to finish any silent push or empty drain.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_esc_decode(logic enable);
        cfg_we   <= 1'b1;
        cfg_data <= enable;
        @(posedge clk);
        cfg_we <= 1'b0;
        chk.esc_decode = enable;
    endtask

    // One random, mostly well-formed key sequence.
    task automatic send_random_sequence();
        int unsigned roll;
        int unsigned ndig;
        int unsigned pick;
        logic [7:0]  finals [10];
        finals = '{CH_UA, CH_UB, CH_UC, CH_UD, CH_UF, CH_UH, CH_LA, CH_LE, CH_LF, CH_TILDE};
        roll = $urandom_range(99);
        if (roll < 35) begin
            send_byte(CH_ESC);
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_byte(CH_LBRACK);
                ndig = ($urandom_range(9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 5);
                repeat (ndig) send_byte(CH_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(9) == 0) send_byte(CH_SEMI);
                if ($urandom_range(9) == 0) send_any_byte();
                else send_byte(finals[$urandom_range(9)]);
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0: send_byte(CH_HASH);
                    1: send_byte(CH_PCT);
                    2: send_byte(CH_LPAREN);
                    default: send_byte(CH_RPAREN);
                endcase
                send_any_byte();
            end else begin
                send_any_byte();
            end
        end else if (roll < 50) begin
            if ($urandom_range(1)) send_byte(8'($urandom_range(LEAD1_HI, LEAD1_LO)));
            else send_byte(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
            send_any_byte();
        end else if (roll < 60) begin
            send_byte(CH_NUL);
            send_any_byte();
        end else if (roll < 80) begin
            send_op(OP_BYTE, 16'($urandom_range(16'hFFFF)));
        end else begin
            repeat ($urandom_range(1, 5)) send_op(OP_PUSH, 16'($urandom_range(16'hFFFF)));
            if ($urandom_range(1)) send_op(OP_DRAIN, 16'($urandom_range(16'hFFFF)));
            else send_any_byte();
        end
    endtask

    task automatic run_random(int target);
        while (sent_count < target) send_random_sequence();
    endtask

    // Receiver: random stalls, or a long hold-off on request.
    initial begin : result_side
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Check every result taken; out_stall is read as it stood at the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) chk.check_result(out_item);
    end

    // Abort when neither side has moved a request for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        chk = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every operation and parser corner.
        set_esc_decode(1'b1);
        send_op(OP_BYTE, 16'hFF61);                               // upper bits ignored
        send_byte(CH_NUL);    send_byte(8'hFF);                   // extended key
        send_byte(LEAD1_LO);  send_byte(8'h40);                   // double-byte, low lead
        send_byte(LEAD2_HI);  send_byte(8'hFF);                   // double-byte, high lead
        send_byte(CH_ESC);    send_byte(CH_LBRACK); send_byte(CH_UA);
        send_byte(CH_ESC);    send_byte(CH_LBRACK);
        send_byte(CH_ZERO + 8'd3); send_byte(CH_TILDE);           // delete
        send_byte(CH_ESC);    send_byte(CH_LBRACK);
        send_byte(CH_SEMI);   send_byte(CH_UH);                   // ';' kills the arrow
        send_byte(CH_ESC);    send_byte(CH_HASH);   send_byte(CH_UB);  // skip one byte
        send_byte(CH_ESC);    send_byte(8'h78);                   // unknown escape
        send_op(OP_PUSH, 16'hFFFF);
        send_op(OP_PUSH, 16'h0000);
        send_op(OP_DRAIN, 16'h0000);
        send_op(OP_DRAIN, 16'hFFFF);                              // empty drain
        wait_drained();

        // Escape decoding off: ESC comes back as a key of its own.
        set_esc_decode(1'b0);
        send_byte(CH_ESC);    send_byte(CH_LBRACK);
        send_byte(LEAD1_HI);  send_byte(LEAD2_LO);
        wait_drained();

        // Random traffic with escapes decoded.
        set_esc_decode(1'b1);
        run_random(45);

        // Back the block up: hold the output while filling and overflowing
        // the stack, then drain everything at once.
        wait_drained();
        rx_hold_req = 1'b1;
        repeat (STACK_DEPTH + 1) send_op(OP_PUSH, 16'($urandom_range(16'hFFFF)));
        send_op(OP_DRAIN, 16'($urandom_range(16'hFFFF)));
        repeat (6) send_any_byte();
        wait_drained();

        set_esc_decode(1'b0);
        run_random(sent_count + 12);
        wait_drained();

        // Closing stretch with no idling on either side.
        set_esc_decode(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(sent_count + 25);
        wait_drained();

        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
